// ----- sv/cycle_deadline_monitor_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the cycle deadline monitor
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CYCLE_DEADLINE_MONITOR_TOP_ASSERT_SVH
`define CYCLE_DEADLINE_MONITOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CDM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cdm assertion failed");
`define CDM_ASSERT_NEXT(lbl, pre, post) \
  `CDM_ASSERT(lbl, (pre) |=> (post))
`else
`define CDM_ASSERT(lbl, prop)
`define CDM_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ----- sv/cdm_pkg.sv -----
// ----------------------------------------------------------------------------
// cdm_pkg
// Types, constants and helpers shared by the cycle deadline monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdm_pkg;

  localparam int TIME_W    = 64;
  localparam int LATE_W    = 32;
  localparam int CNT_W     = 32;
  localparam int PERIOD_W  = 24;
  localparam int ESC_W     = 8;
  localparam int TRIM_W    = 32;
  localparam int HIST_BINS = 8;
  localparam int BIN_W     = $clog2(HIST_BINS);
  localparam int NUM_EDGES = HIST_BINS - 1;
  localparam int DIV_CNT_W = $clog2(LATE_W);
  localparam int CFG_IDX_W = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);
  localparam logic [ESC_W-1:0]    ESC_DEFAULT  = ESC_W'(3);

  // x / 10 == (x * ceil(2^27 / 10)) >> 27, exact for x < 2^26
  localparam logic [PERIOD_W-1:0] DIV10_RECIP = 24'hCCCCCD;
  localparam int                  DIV10_SHIFT = 27;
  localparam logic [PERIOD_W-1:0] DIV10_RESET = PERIOD_W'(1000 / 10);

  localparam logic [LATE_W-1:0] BIN_EDGE [NUM_EDGES] = '{
    32'd10, 32'd25, 32'd50, 32'd100, 32'd250, 32'd500, 32'd1000
  };

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LATE_WARN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCALATE = 2'd2;

  typedef enum logic [1:0] {
    KIND_ACTIVATE   = 2'd0,
    KIND_DEACTIVATE = 2'd1,
    KIND_TICK       = 2'd2,
    KIND_TRIM       = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_CLASS,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    kind_e                     kind;
    logic [TIME_W-1:0]         now_us;
    logic signed [TRIM_W-1:0]  trim_us;
    logic [BIN_W-1:0]          hist_index;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] next_deadline_us;
    logic [LATE_W-1:0] late_us;
    logic              overrun;
    logic              missed;
    logic              escalate;
    logic [CNT_W-1:0]  hist_count;
    logic [LATE_W-1:0] worst_late_us;
    logic [CNT_W-1:0]  overrun_total;
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  skipped_total;
    logic [CNT_W-1:0]  tick_total;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic classify;
    logic skip_add;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic logic [BIN_W-1:0] bin_of(input logic [LATE_W-1:0] late);
    logic [BIN_W-1:0] idx;
    idx = BIN_W'(HIST_BINS - 1);
    for (int i = NUM_EDGES - 1; i >= 0; i--) begin
      if (late <= BIN_EDGE[i]) idx = BIN_W'(i);
    end
    return idx;
  endfunction

endpackage

// ----- sv/cycle_deadline_monitor_top.sv -----
// ----------------------------------------------------------------------------
// cycle_deadline_monitor_top
// Periodic deadline monitor: lateness histogram, overrun/miss counting,
// skip re-anchoring and escalation.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                 Payload
// in        in   in_valid_i / in_ready_o   in_item_i  (in_item_t)
// out       out  out_valid_o / out_ready_i out_item_o (out_item_t)
// cfg       in   cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One item at a time: the item is captured, measured and classified, then
// the result is registered. An overrun tick with a nonzero period also runs
// the 32-step serial divider before the result is registered. The next item is
// taken once the result is registered, even if it has not been read.
// A stalled output holds the sequencer in its last step.
// Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cycle_deadline_monitor_top
  import cdm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PERIOD_W-1:0]  cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  cdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cdm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- sv/cdm_div.sv -----
// ----------------------------------------------------------------------------
// cdm_div
// Restoring divider, one quotient bit per cycle, for skipped periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdm_div
  import cdm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [LATE_W-1:0]   dividend_i,
  input  logic [PERIOD_W-1:0] divisor_i,
  output logic [LATE_W-1:0]   quotient_o,
  output logic                done_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [LATE_W-1:0]    quo_q, quo_d;
  logic [PERIOD_W-1:0]  rem_q, rem_d;
  logic [PERIOD_W-1:0]  dsr_q;
  logic [PERIOD_W:0]    shifted;
  logic                 fits;

  always_comb begin
    shifted = {rem_q, quo_q[LATE_W-1]};
    fits    = shifted >= {1'b0, dsr_q};
    rem_d   = fits ? PERIOD_W'(shifted - {1'b0, dsr_q}) : shifted[PERIOD_W-1:0];
    quo_d   = {quo_q[LATE_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ----- sv/cdm_datapath.sv -----
// ----------------------------------------------------------------------------
// cdm_datapath
// Config registers, deadline and statistics, lateness measure, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdm_datapath
  import cdm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PERIOD_W-1:0]  cfg_wdata_i,
  input  in_item_t             in_item_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o
);

  // configuration
  logic [PERIOD_W-1:0] period_q, warn_q, div10_q, div10_d;
  logic [ESC_W-1:0]    esc_q;
  logic [2*PERIOD_W-1:0] div10_prod;

  // captured item
  kind_e                    kind_q;
  logic [TIME_W-1:0]        now_q;
  logic signed [TRIM_W-1:0] trim_q;
  logic [BIN_W-1:0]         hidx_q;

  // monitor state
  logic              active_q;
  logic [TIME_W-1:0] deadline_q;
  logic [CNT_W-1:0]  bins_q [HIST_BINS];
  logic [LATE_W-1:0] worst_q;
  logic [CNT_W-1:0]  ovr_cnt_q, streak_q, miss_cnt_q, skip_q, tick_q;

  // per-item work
  logic [LATE_W-1:0] late_q, late_d;
  logic              ge_hold;
  logic              ovr_f_q, miss_f_q, esc_f_q;

  logic              out_valid_q;
  out_item_t         out_q;

  logic [TIME_W:0]    diff;
  logic               ge;
  logic               tick_ev, hit, over, miss, esc, restart;
  logic [PERIOD_W-1:0] warn;
  logic [ESC_W-1:0]   esc_n;
  logic [CNT_W-1:0]   streak_inc;
  logic [BIN_W-1:0]   bin;
  logic signed [TRIM_W-1:0] lim_s, neg_lim_s, clamp;
  logic [TIME_W-1:0]  add_base, add_val, dl_sum;
  logic               dl_we;
  logic [LATE_W-1:0]  quotient;
  logic               div_done;

  // ---- config and period / 10 ----
  assign div10_prod = {{PERIOD_W{1'b0}}, period_q} * {{PERIOD_W{1'b0}}, DIV10_RECIP};
  assign div10_d    = PERIOD_W'(div10_prod >> DIV10_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      warn_q   <= '0;
      esc_q    <= '0;
      div10_q  <= DIV10_RESET;
    end else begin
      div10_q <= div10_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PERIOD:    period_q <= cfg_wdata_i;
          REG_LATE_WARN: warn_q   <= cfg_wdata_i;
          REG_ESCALATE:  esc_q    <= cfg_wdata_i[ESC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---- lateness ----
  always_comb begin
    diff   = {1'b0, now_q} - {1'b0, deadline_q};
    ge     = !diff[TIME_W];
    late_d = '0;
    if (kind_q == KIND_TICK && active_q && ge) begin
      late_d = (|diff[TIME_W-1:LATE_W]) ? '1 : diff[LATE_W-1:0];
    end
  end

  // ---- classification ----
  always_comb begin
    tick_ev    = (kind_q == KIND_TICK) && active_q;
    // late_q is nonzero-capable only for ticks at or past the deadline
    hit        = tick_ev && ge_hold;
    over       = hit && (late_q >= {{(LATE_W-PERIOD_W){1'b0}}, period_q});
    warn       = (warn_q != '0) ? warn_q : div10_q;
    miss       = hit && !over && (late_q >= {{(LATE_W-PERIOD_W){1'b0}}, warn});
    esc_n      = (esc_q != '0) ? esc_q : ESC_DEFAULT;
    streak_inc = streak_q + 1'b1;
    esc        = over && (streak_inc == {{(CNT_W-ESC_W){1'b0}}, esc_n});
    bin        = bin_of(late_q);
    restart    = (kind_q == KIND_ACTIVATE) && !active_q;

    lim_s     = $signed({{(TRIM_W-PERIOD_W+1){1'b0}}, div10_q[PERIOD_W-1:1]});
    neg_lim_s = -lim_s;
    if (trim_q > lim_s) clamp = lim_s;
    else if (trim_q < neg_lim_s) clamp = neg_lim_s;
    else clamp = trim_q;

    add_base = (restart || over) ? now_q : deadline_q;
    add_val  = (kind_q == KIND_TRIM) ? {{(TIME_W-TRIM_W){clamp[TRIM_W-1]}}, clamp}
                                     : {{(TIME_W-PERIOD_W){1'b0}}, period_q};
    dl_sum   = add_base + add_val;
    dl_we    = restart || tick_ev || (kind_q == KIND_TRIM);
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_item_i.kind;
      now_q  <= in_item_i.now_us;
      trim_q <= in_item_i.trim_us;
      hidx_q <= in_item_i.hist_index;
    end
    if (cmd_i.calc) begin
      late_q  <= late_d;
      ge_hold <= ge;
    end
    if (cmd_i.classify) begin
      ovr_f_q  <= over;
      miss_f_q <= miss;
      esc_f_q  <= esc;
    end
    if (cmd_i.emit) begin
      out_q.next_deadline_us <= deadline_q;
      out_q.late_us          <= late_q;
      out_q.overrun          <= ovr_f_q;
      out_q.missed           <= miss_f_q;
      out_q.escalate         <= esc_f_q;
      out_q.hist_count       <= bins_q[hidx_q];
      out_q.worst_late_us    <= worst_q;
      out_q.overrun_total    <= ovr_cnt_q;
      out_q.miss_total       <= miss_cnt_q;
      out_q.skipped_total    <= skip_q;
      out_q.tick_total       <= tick_q;
    end
  end

  // ---- monitor state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      deadline_q <= '0;
      for (int i = 0; i < HIST_BINS; i++) bins_q[i] <= '0;
      worst_q    <= '0;
      ovr_cnt_q  <= '0;
      streak_q   <= '0;
      miss_cnt_q <= '0;
      skip_q     <= '0;
      tick_q     <= '0;
    end else begin
      if (cmd_i.classify) begin
        if (dl_we) deadline_q <= dl_sum;
        if (restart) begin
          active_q <= 1'b1;
          for (int i = 0; i < HIST_BINS; i++) bins_q[i] <= '0;
          worst_q    <= '0;
          ovr_cnt_q  <= '0;
          streak_q   <= '0;
          miss_cnt_q <= '0;
          skip_q     <= '0;
          tick_q     <= '0;
        end else if (kind_q == KIND_DEACTIVATE) begin
          active_q <= 1'b0;
        end else if (tick_ev) begin
          tick_q <= tick_q + 1'b1;
          if (hit) begin
            bins_q[bin] <= bins_q[bin] + 1'b1;
            if (late_q > worst_q) worst_q <= late_q;
          end
          if (over) begin
            ovr_cnt_q <= ovr_cnt_q + 1'b1;
            streak_q  <= streak_inc;
          end else begin
            streak_q <= '0;
          end
          if (miss) miss_cnt_q <= miss_cnt_q + 1'b1;
        end
      end
      if (cmd_i.skip_add) skip_q <= skip_q + quotient;
    end
  end

  // ---- skipped periods = late / period ----
  cdm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.classify && sts_o.need_div),
    .dividend_i (late_q),
    .divisor_i  (period_q),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.need_div = over && (period_q != '0);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- sv/cdm_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdm_ctrl
// Sequencer: capture, measure, classify, divide, hand off the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cycle_deadline_monitor_top_assert.svh"

module cdm_ctrl
  import cdm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_CALC;
      S_CALC:  state_d = S_CLASS;
      S_CLASS: state_d = sts_i.need_div ? S_DIV : S_DONE;
      S_DIV:   if (sts_i.div_done) state_d = S_DONE;
      S_DONE:  if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_CALC:  cmd_o.calc = 1'b1;
      S_CLASS: cmd_o.classify = 1'b1;
      S_DIV:   cmd_o.skip_add = sts_i.div_done;
      S_DONE:  cmd_o.emit = sts_i.out_free;
      default: ;
    endcase
  end

  `CDM_ASSERT_NEXT(a_accept_to_calc, in_valid_i && in_ready_o, state_q == S_CALC)
  `CDM_ASSERT(a_done_only_in_div, sts_i.div_done |-> state_q == S_DIV)
  `CDM_ASSERT_NEXT(a_div_waits, state_q == S_DIV && !sts_i.div_done, state_q == S_DIV)
  `CDM_ASSERT_NEXT(a_no_div_skips, state_q == S_CLASS && !sts_i.need_div, state_q == S_DONE)

endmodule
